// ===== design/pmt_pkg.sv =====
// ----------------------------------------------------------------------------
// pmt_pkg
// shared types and constants for the membership table
// ----------------------------------------------------------------------------
package pmt_pkg;

    localparam int MAX_SUBJECTS_DEF = 16;
    localparam int MAX_MEMBERS_DEF  = 16;
    localparam int RESULT_CAP       = 16;

    localparam logic [1:0] KIND_SUB   = 2'd0;
    localparam logic [1:0] KIND_PUB   = 2'd1;
    localparam logic [1:0] KIND_UNSUB = 2'd2;
    localparam logic [1:0] KIND_DISC  = 2'd3;

    localparam logic RES_ACK    = 1'b0;
    localparam logic RES_NOTIFY = 1'b1;

    localparam int MEM_W = 56;  // addr, port, conn

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIND_RD,
        ST_FIND_CHK,
        ST_DISPATCH,
        ST_SUB_WR,
        ST_PUB_RD,
        ST_PUB_CHK,
        ST_ACK,
        ST_NOT_RD,
        ST_NOT_CHK,
        ST_NOT_OUT,
        ST_PRG_RD,
        ST_PRG_CHK,
        ST_PRG_DONE
    } state_t;

endpackage

// ===== design/pmt_ram.sv =====
// ----------------------------------------------------------------------------
// pmt_ram
// generic single port write, single port read ram with registered read
// ----------------------------------------------------------------------------
module pmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      aclk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

// ===== design/pubsub_membership_table.sv =====
// ----------------------------------------------------------------------------
// pubsub_membership_table
// subscription table keyed by subject tag with publish fan-out
// ----------------------------------------------------------------------------
// usage
//   s_ channel carries one request beat: subscribe, publish, unsubscribe or
//   disconnect. m_ channel carries result beats: for a known subject, an ack
//   to the publisher and then, if it is a member, one notify per other
//   member, m_last on the final beat of a request. a small sequencer walks
//   the tables through one memory read port, one request at a time; s_ready
//   is high only while the sequencer is idle.
//   steps from accept: the search compares subjects one at a time, then the
//   request is dispatched; subscribe then writes the new member; publish
//   scans the membership, sends the ack, then reads each other member and
//   sends its notify, skipping the publisher; unsubscribe compacts the list;
//   disconnect skips the search and compacts the list of every subject.
//   the result register holds its beat while m_ready is low; the sequencer
//   waits in the ack or notify state, so a stalled receiver stalls the walk
//   with nothing lost. a new request may be accepted while the final beat of
//   the previous one still waits in the result register.
//   reset (aresetn low, synchronous) clears the subject count, every member
//   count and the result valid flag; tag and member memories need no clearing
//   pass since they are only read below the counts.
//   subscribe to a new subject with a full subject table, or to a full
//   member list, is dropped silently; unsubscribe and disconnect compact
//   the member list in place, keeping order.
// ----------------------------------------------------------------------------
module pubsub_membership_table #(
    parameter int MAX_SUBJECTS = pmt_pkg::MAX_SUBJECTS_DEF,
    parameter int MAX_MEMBERS  = pmt_pkg::MAX_MEMBERS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [31:0] s_subject_id,
    input  logic [31:0] s_client_addr,
    input  logic [15:0] s_client_port,
    input  logic [7:0]  s_conn_handle,
    input  logic        s_pub_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_result_kind,
    output logic        m_ack_ok,
    output logic [31:0] m_out_subject,
    output logic [31:0] m_dest_addr,
    output logic [15:0] m_dest_port,
    output logic [7:0]  m_dest_conn,
    output logic        m_out_value,
    output logic        m_last
);
    localparam int SW  = (MAX_SUBJECTS > 1) ? $clog2(MAX_SUBJECTS) : 1;
    localparam int SCW = $clog2(MAX_SUBJECTS + 1);
    localparam int MW  = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
    localparam int MCW = $clog2(MAX_MEMBERS + 1);
    localparam int DEPTH = MAX_SUBJECTS * MAX_MEMBERS;
    localparam int AW  = $clog2(DEPTH) > 0 ? $clog2(DEPTH) : 1;
    localparam int RCW = $clog2(pmt_pkg::RESULT_CAP + 1);

    // request registers
    logic [1:0]  kind_reg;
    logic [31:0] subj_reg, addr_reg;
    logic [15:0] port_reg;
    logic [7:0]  conn_reg;
    logic        val_reg;

    pmt_pkg::state_t state_reg, state_next;

    logic [SCW-1:0] subj_cnt_reg, subj_cnt_next;
    logic [MCW-1:0] mcnt_reg [MAX_SUBJECTS];
    logic           mcnt_we;
    logic [MCW-1:0] mcnt_wd;
    logic [SW-1:0]  si_reg, si_next;       // subject index
    logic           found_reg, found_next;
    logic [MCW-1:0] rd_reg, rd_next;       // member read index
    logic [MCW-1:0] wr_reg, wr_next;       // compaction write index
    logic           member_reg, member_next;
    logic [RCW-1:0] ncnt_reg, ncnt_next;   // notifies this publish will send
    logic [RCW-1:0] sent_reg, sent_next;   // notifies sent so far

    // result register, held until the receiver takes the beat
    logic        out_valid_reg, out_valid_next;
    logic        out_load;
    logic        o_kind_reg, o_kind_next;
    logic        o_ok_reg, o_ok_next;
    logic        o_val_reg, o_val_next;
    logic        o_last_reg, o_last_next;
    logic [31:0] o_subj_reg, o_subj_next;
    logic [55:0] o_rec_reg, o_rec_next;

    // tag memory
    logic        tag_we;
    logic [31:0] tag_rd;

    pmt_ram #(.WIDTH(32), .DEPTH(MAX_SUBJECTS)) u_tags (
        .aclk(aclk), .wr_en(tag_we), .wr_addr(si_reg), .wr_data(subj_reg),
        .rd_addr(si_reg), .rd_data(tag_rd)
    );

    // member memory
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [pmt_pkg::MEM_W-1:0] mem_wd, mem_rd;

    pmt_ram #(.WIDTH(pmt_pkg::MEM_W), .DEPTH(DEPTH)) u_members (
        .aclk(aclk), .wr_en(mem_we), .wr_addr(mem_wa), .wr_data(mem_wd),
        .rd_addr(mem_ra), .rd_data(mem_rd)
    );

    logic [MCW-1:0] cur_cnt;
    logic           rd_match;
    logic           out_free;
    logic           more_subj;
    logic           ack_last;
    logic           not_last;

    assign cur_cnt   = mcnt_reg[si_reg];
    assign rd_match  = (mem_rd[55:24] == addr_reg);
    assign out_free  = !out_valid_reg || m_ready;
    assign more_subj = (SCW'(si_reg) + SCW'(1)) < subj_cnt_reg;
    assign ack_last  = !member_reg || (ncnt_reg == '0);
    assign not_last  = (sent_reg + RCW'(1)) == ncnt_reg;

    function automatic logic [AW-1:0] maddr(input logic [SW-1:0] s,
                                            input logic [MCW-1:0] m);
        logic [AW+MW:0] a;
        a = (AW+MW+1)'(s) * (AW+MW+1)'(MAX_MEMBERS) + (AW+MW+1)'(m);
        return a[AW-1:0];
    endfunction

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pmt_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_kind == pmt_pkg::KIND_DISC) begin
                        state_next = (subj_cnt_reg == '0) ? pmt_pkg::ST_IDLE
                                                          : pmt_pkg::ST_PRG_RD;
                    end else begin
                        state_next = (subj_cnt_reg == '0) ? pmt_pkg::ST_DISPATCH
                                                          : pmt_pkg::ST_FIND_RD;
                    end
                end
            end
            pmt_pkg::ST_FIND_RD:  state_next = pmt_pkg::ST_FIND_CHK;
            pmt_pkg::ST_FIND_CHK: begin
                if (tag_rd == subj_reg || !more_subj) begin
                    state_next = pmt_pkg::ST_DISPATCH;
                end else begin
                    state_next = pmt_pkg::ST_FIND_RD;
                end
            end
            pmt_pkg::ST_DISPATCH: begin
                case (kind_reg)
                    pmt_pkg::KIND_SUB: begin
                        if (found_reg ? (cur_cnt < MCW'(MAX_MEMBERS))
                                      : (subj_cnt_reg < SCW'(MAX_SUBJECTS))) begin
                            state_next = pmt_pkg::ST_SUB_WR;
                        end else begin
                            state_next = pmt_pkg::ST_IDLE;
                        end
                    end
                    pmt_pkg::KIND_PUB: begin
                        if (!found_reg) state_next = pmt_pkg::ST_IDLE;
                        else if (cur_cnt == '0) state_next = pmt_pkg::ST_ACK;
                        else state_next = pmt_pkg::ST_PUB_RD;
                    end
                    default: begin
                        if (!found_reg || cur_cnt == '0) state_next = pmt_pkg::ST_IDLE;
                        else state_next = pmt_pkg::ST_PRG_RD;
                    end
                endcase
            end
            pmt_pkg::ST_SUB_WR:  state_next = pmt_pkg::ST_IDLE;
            pmt_pkg::ST_PUB_RD:  state_next = pmt_pkg::ST_PUB_CHK;
            pmt_pkg::ST_PUB_CHK: begin
                if (rd_reg + MCW'(1) >= cur_cnt) state_next = pmt_pkg::ST_ACK;
                else state_next = pmt_pkg::ST_PUB_RD;
            end
            pmt_pkg::ST_ACK: begin
                if (out_free) begin
                    state_next = ack_last ? pmt_pkg::ST_IDLE : pmt_pkg::ST_NOT_RD;
                end
            end
            pmt_pkg::ST_NOT_RD:  state_next = pmt_pkg::ST_NOT_CHK;
            pmt_pkg::ST_NOT_CHK: begin
                state_next = rd_match ? pmt_pkg::ST_NOT_RD : pmt_pkg::ST_NOT_OUT;
            end
            pmt_pkg::ST_NOT_OUT: begin
                if (out_free) begin
                    state_next = not_last ? pmt_pkg::ST_IDLE : pmt_pkg::ST_NOT_RD;
                end
            end
            pmt_pkg::ST_PRG_RD: begin
                if (rd_reg >= cur_cnt) state_next = pmt_pkg::ST_PRG_DONE;
                else state_next = pmt_pkg::ST_PRG_CHK;
            end
            pmt_pkg::ST_PRG_CHK: state_next = pmt_pkg::ST_PRG_RD;
            pmt_pkg::ST_PRG_DONE: begin
                if (kind_reg == pmt_pkg::KIND_DISC && more_subj) begin
                    state_next = pmt_pkg::ST_PRG_RD;
                end else begin
                    state_next = pmt_pkg::ST_IDLE;
                end
            end
            default: state_next = pmt_pkg::ST_IDLE;
        endcase
    end

    // datapath control and result beat
    always_comb begin
        si_next       = si_reg;
        found_next    = found_reg;
        rd_next       = rd_reg;
        wr_next       = wr_reg;
        member_next   = member_reg;
        ncnt_next     = ncnt_reg;
        sent_next     = sent_reg;
        subj_cnt_next = subj_cnt_reg;
        mcnt_we = 1'b0;
        mcnt_wd = wr_reg;
        tag_we  = 1'b0;
        mem_we  = 1'b0;
        mem_wa  = maddr(si_reg, wr_reg);
        mem_wd  = mem_rd;
        mem_ra  = maddr(si_reg, rd_reg);
        out_load    = 1'b0;
        o_kind_next = o_kind_reg;
        o_ok_next   = o_ok_reg;
        o_val_next  = o_val_reg;
        o_last_next = o_last_reg;
        o_subj_next = o_subj_reg;
        o_rec_next  = o_rec_reg;
        case (state_reg)
            pmt_pkg::ST_IDLE: begin
                si_next     = '0;
                found_next  = 1'b0;
                rd_next     = '0;
                wr_next     = '0;
                member_next = 1'b0;
                ncnt_next   = '0;
                sent_next   = '0;
            end
            pmt_pkg::ST_FIND_CHK: begin
                if (tag_rd == subj_reg) found_next = 1'b1;
                else if (more_subj) si_next = si_reg + SW'(1);
            end
            pmt_pkg::ST_DISPATCH: begin
                // a new subject takes the next free slot
                if (kind_reg == pmt_pkg::KIND_SUB && !found_reg &&
                    subj_cnt_reg < SCW'(MAX_SUBJECTS)) begin
                    si_next = SW'(subj_cnt_reg);
                end
            end
            pmt_pkg::ST_SUB_WR: begin
                // append at the end of the list, a new subject starts empty
                mem_we  = 1'b1;
                mem_wa  = maddr(si_reg, cur_cnt);
                mem_wd  = {addr_reg, port_reg, conn_reg};
                mcnt_we = 1'b1;
                mcnt_wd = cur_cnt + MCW'(1);
                if (!found_reg) begin
                    tag_we = 1'b1;
                    subj_cnt_next = subj_cnt_reg + SCW'(1);
                end
            end
            pmt_pkg::ST_PUB_CHK: begin
                // count the notifies up front so the last flag is known
                if (rd_match) begin
                    member_next = 1'b1;
                end else if (ncnt_reg < RCW'(pmt_pkg::RESULT_CAP - 1)) begin
                    ncnt_next = ncnt_reg + RCW'(1);
                end
                rd_next = rd_reg + MCW'(1);
            end
            pmt_pkg::ST_ACK: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    o_kind_next = pmt_pkg::RES_ACK;
                    o_ok_next   = member_reg;
                    o_val_next  = 1'b0;
                    o_last_next = ack_last;
                    o_subj_next = subj_reg;
                    o_rec_next  = {addr_reg, port_reg, conn_reg};
                    rd_next     = '0;
                end
            end
            pmt_pkg::ST_NOT_CHK: begin
                if (rd_match) rd_next = rd_reg + MCW'(1);
            end
            pmt_pkg::ST_NOT_OUT: begin
                // read address is held, so mem_rd still has this member
                if (out_free) begin
                    out_load    = 1'b1;
                    o_kind_next = pmt_pkg::RES_NOTIFY;
                    o_ok_next   = 1'b0;
                    o_val_next  = val_reg;
                    o_last_next = not_last;
                    o_subj_next = subj_reg;
                    o_rec_next  = mem_rd;
                    sent_next   = sent_reg + RCW'(1);
                    rd_next     = rd_reg + MCW'(1);
                end
            end
            pmt_pkg::ST_PRG_CHK: begin
                rd_next = rd_reg + MCW'(1);
                if (!rd_match) begin
                    mem_we  = 1'b1;
                    wr_next = wr_reg + MCW'(1);
                end
            end
            pmt_pkg::ST_PRG_DONE: begin
                mcnt_we = 1'b1;
                mcnt_wd = wr_reg;
                rd_next = '0;
                wr_next = '0;
                if (more_subj) si_next = si_reg + SW'(1);
            end
            default: begin
            end
        endcase
        if (out_load) out_valid_next = 1'b1;
        else if (m_ready) out_valid_next = 1'b0;
        else out_valid_next = out_valid_reg;
    end

    assign s_ready = (state_reg == pmt_pkg::ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pmt_pkg::ST_IDLE;
            subj_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_SUBJECTS; i++) mcnt_reg[i] <= '0;
            si_reg <= '0; found_reg <= 1'b0; rd_reg <= '0; wr_reg <= '0;
            member_reg <= 1'b0; ncnt_reg <= '0; sent_reg <= '0;
        end else begin
            state_reg     <= state_next;
            subj_cnt_reg  <= subj_cnt_next;
            out_valid_reg <= out_valid_next;
            si_reg <= si_next; found_reg <= found_next; rd_reg <= rd_next;
            wr_reg <= wr_next; member_reg <= member_next;
            ncnt_reg <= ncnt_next; sent_reg <= sent_next;
            if (mcnt_we) mcnt_reg[si_reg] <= mcnt_wd;
        end
    end

    always_ff @(posedge aclk) begin
        o_kind_reg <= o_kind_next;
        o_ok_reg   <= o_ok_next;
        o_val_reg  <= o_val_next;
        o_last_reg <= o_last_next;
        o_subj_reg <= o_subj_next;
        o_rec_reg  <= o_rec_next;
    end

    always_ff @(posedge aclk) begin
        if (state_reg == pmt_pkg::ST_IDLE && s_valid) begin
            kind_reg <= s_kind;
            subj_reg <= s_subject_id;
            addr_reg <= s_client_addr;
            port_reg <= s_client_port;
            conn_reg <= s_conn_handle;
            val_reg  <= s_pub_value;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_result_kind = o_kind_reg;
    assign m_ack_ok      = o_ok_reg;
    assign m_out_subject = o_subj_reg;
    assign m_dest_addr   = o_rec_reg[55:24];
    assign m_dest_port   = o_rec_reg[23:8];
    assign m_dest_conn   = o_rec_reg[7:0];
    assign m_out_value   = o_val_reg;
    assign m_last        = o_last_reg;
endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// checks the pub/sub membership table: requests are sent in random bursts,
// a local model of the subject and member lists predicts every ack and
// notify beat, and a checker compares each result beat field by field
// ----------------------------------------------------------------------------
module tb;

    localparam int NSUBJ = pmt_pkg::MAX_SUBJECTS_DEF;
    localparam int NMEMB = pmt_pkg::MAX_MEMBERS_DEF;

    typedef struct packed {
        logic        rkind;
        logic        ok;
        logic [31:0] subj;
        logic [31:0] addr;
        logic [15:0] port;
        logic [7:0]  conn;
        logic        val;
        logic        last;
    } result_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_kind = pmt_pkg::KIND_SUB;
    logic [31:0] s_subject_id = '0;
    logic [31:0] s_client_addr = '0;
    logic [15:0] s_client_port = '0;
    logic [7:0]  s_conn_handle = '0;
    logic        s_pub_value = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_result_kind;
    logic        m_ack_ok;
    logic [31:0] m_out_subject;
    logic [31:0] m_dest_addr;
    logic [15:0] m_dest_port;
    logic [7:0]  m_dest_conn;
    logic        m_out_value;
    logic        m_last;

    pubsub_membership_table #(.MAX_SUBJECTS(NSUBJ), .MAX_MEMBERS(NMEMB)) i_dut (.*);

    // model state of the subscription table
    logic [31:0] tag_mdl [NSUBJ];
    int          nsubj_mdl;
    int          nmemb_mdl [NSUBJ];
    logic [31:0] addr_mdl [NSUBJ][NMEMB];
    logic [15:0] port_mdl [NSUBJ][NMEMB];
    logic [7:0]  conn_mdl [NSUBJ][NMEMB];

    result_beat_t pending_results [$];
    int  n_errors = 0;
    int  n_beats  = 0;
    int  n_reqs   = 0;
    bit  hold_off = 1'b0;   // long receiver stall requested
    int  hold_cycles = 0;

    // small pools so requests keep hitting known subjects and members
    logic [31:0] subj_pool [8];
    logic [31:0] addr_pool [6];

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic void add_expected(result_beat_t r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic int lookup_subject(logic [31:0] tag);
        for (int i = 0; i < nsubj_mdl; i++)
            if (tag_mdl[i] == tag) return i;
        return -1;
    endfunction

    function automatic void drop_members(int s, logic [31:0] a);
        int wr;
        wr = 0;
        for (int rd = 0; rd < nmemb_mdl[s]; rd++) begin
            if (addr_mdl[s][rd] != a) begin
                addr_mdl[s][wr] = addr_mdl[s][rd];
                port_mdl[s][wr] = port_mdl[s][rd];
                conn_mdl[s][wr] = conn_mdl[s][rd];
                wr++;
            end
        end
        nmemb_mdl[s] = wr;
    endfunction

    function automatic void predict_request(logic [1:0] k, logic [31:0] sj, logic [31:0] a,
                                            logic [15:0] p, logic [7:0] c, logic v);
        int s;
        bit member;
        int first;
        result_beat_t r;
        s = lookup_subject(sj);
        member = 1'b0;
        case (k)
            pmt_pkg::KIND_SUB: begin
                if (s < 0 && nsubj_mdl < NSUBJ) begin
                    s = nsubj_mdl;
                    tag_mdl[s] = sj;
                    nmemb_mdl[s] = 0;
                    nsubj_mdl++;
                end
                if (s >= 0 && nmemb_mdl[s] < NMEMB) begin
                    addr_mdl[s][nmemb_mdl[s]] = a;
                    port_mdl[s][nmemb_mdl[s]] = p;
                    conn_mdl[s][nmemb_mdl[s]] = c;
                    nmemb_mdl[s]++;
                end
            end
            pmt_pkg::KIND_PUB: begin
                if (s >= 0) begin
                    for (int i = 0; i < nmemb_mdl[s]; i++)
                        if (addr_mdl[s][i] == a) member = 1'b1;
                    first = pending_results.size();
                    r = '{pmt_pkg::RES_ACK, member, sj, a, p, c, 1'b0, 1'b0};
                    add_expected(r);
                    if (member)
                        for (int i = 0; i < nmemb_mdl[s]; i++)
                            if (addr_mdl[s][i] != a &&
                                pending_results.size() - first < pmt_pkg::RESULT_CAP) begin
                                r = '{pmt_pkg::RES_NOTIFY, 1'b0, sj, addr_mdl[s][i],
                                      port_mdl[s][i], conn_mdl[s][i], v, 1'b0};
                                add_expected(r);
                            end
                    pending_results[pending_results.size() - 1].last = 1'b1;
                end
            end
            pmt_pkg::KIND_UNSUB: begin
                if (s >= 0) drop_members(s, a);
            end
            default: begin
                for (int i = 0; i < nsubj_mdl; i++) drop_members(i, a);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // sender: one request beat, with random gaps between bursts
    // ------------------------------------------------------------------
    int burst_left = 0;
    bit gaps_on = 1'b1;

    task automatic send_request(logic [1:0] k, logic [31:0] sj, logic [31:0] a,
                                logic [15:0] p, logic [7:0] c, logic v);
        int gap;
        if (gaps_on) begin
            if (burst_left == 0) begin
                gap = $urandom_range(0, 6);
                repeat (gap) @(negedge aclk);
                burst_left = $urandom_range(1, 8);
            end
            burst_left--;
        end
        s_kind = k;
        s_subject_id = sj;
        s_client_addr = a;
        s_client_port = p;
        s_conn_handle = c;
        s_pub_value = v;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_request(k, sj, a, p, c, v);
        n_reqs++;
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    function automatic logic [31:0] pick_subj();
        return ($urandom_range(0, 9) == 0) ? $urandom() : subj_pool[$urandom_range(0, 7)];
    endfunction

    function automatic logic [31:0] pick_addr();
        return ($urandom_range(0, 9) == 0) ? $urandom() : addr_pool[$urandom_range(0, 5)];
    endfunction

    task automatic send_random();
        int roll;
        roll = $urandom_range(0, 99);
        send_request(roll < 45 ? pmt_pkg::KIND_SUB : roll < 85 ? pmt_pkg::KIND_PUB
                     : roll < 96 ? pmt_pkg::KIND_UNSUB : pmt_pkg::KIND_DISC,
                     pick_subj(), pick_addr(), 16'($urandom()),
                     8'($urandom()), 1'($urandom()));
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // receiver: stall pattern of its own, plus the long hold-off
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_off) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 3) != 0) || (n_reqs < 12);
        end
    end

    always @(posedge aclk) begin
        if (hold_off) hold_cycles <= hold_cycles + 1;
    end

    // ------------------------------------------------------------------
    // checker
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        result_beat_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_result_kind, m_ack_ok, m_out_subject, m_dest_addr, m_dest_port,
                    m_dest_conn, m_out_value, m_last};
            n_beats++;
            if (pending_results.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected result beat %p", got);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    n_errors++;
                    if (n_errors <= 10) $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        // publish to an unknown subject, then extremes of every field
        send_request(pmt_pkg::KIND_PUB, 32'hFFFF_FFFF, 32'h0, 16'h0, 8'h0, 1'b1);
        send_request(pmt_pkg::KIND_SUB, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 1'b1);
        send_request(pmt_pkg::KIND_SUB, 32'hFFFF_FFFF, 32'h0, 16'h0, 8'h0, 1'b0);
        send_request(pmt_pkg::KIND_SUB, 32'hFFFF_FFFF, 32'h0, 16'h1234, 8'h5A, 1'b0); // dup
        send_request(pmt_pkg::KIND_PUB, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 1'b1);
        send_request(pmt_pkg::KIND_PUB, 32'hFFFF_FFFF, 32'h0, 16'h0, 8'h0, 1'b0);
        // non-member of a known subject gets a refused ack
        send_request(pmt_pkg::KIND_PUB, 32'hFFFF_FFFF, 32'h5555_AAAA, 16'hAAAA, 8'h55, 1'b1);
        send_request(pmt_pkg::KIND_UNSUB, 32'hFFFF_FFFF, 32'h0, 16'h0, 8'h0, 1'b0);
        send_request(pmt_pkg::KIND_UNSUB, 32'h0, 32'h0, 16'h0, 8'h0, 1'b0);      // no match
        send_request(pmt_pkg::KIND_PUB, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h1, 8'h1, 1'b1);
        send_request(pmt_pkg::KIND_DISC, 32'h0, 32'hFFFF_FFFF, 16'h0, 8'h0, 1'b0);
        send_request(pmt_pkg::KIND_DISC, 32'h0, 32'h7777_7777, 16'h0, 8'h0, 1'b0); // no match
        send_request(pmt_pkg::KIND_PUB, 32'hFFFF_FFFF, 32'h0, 16'h0, 8'h0, 1'b1);
        wait_drained();
    endtask

    task automatic test_full_tables();
        // fill one member list past its limit, then publish a full fan-out
        for (int i = 0; i < NMEMB + 2; i++)
            send_request(pmt_pkg::KIND_SUB, 32'h0, 32'h100 + i, 16'(i), 8'(i), 1'b0);
        send_request(pmt_pkg::KIND_PUB, 32'h0, 32'h100, 16'h9, 8'h9, 1'b1);
        // fill the subject table past its limit
        for (int i = 0; i < NSUBJ + 2; i++)
            send_request(pmt_pkg::KIND_SUB, 32'h1000 + i, 32'h200, 16'h2, 8'h2, 1'b0);
        send_request(pmt_pkg::KIND_PUB, 32'h1000 + NSUBJ, 32'h200, 16'h2, 8'h2, 1'b0);
        wait_drained();
    endtask

    task automatic test_backpressure();
        // long receiver hold-off while requests keep coming
        gaps_on = 1'b0;
        hold_off = 1'b1;
        fork
            for (int i = 0; i < 8; i++)
                send_request(pmt_pkg::KIND_PUB, 32'h0, 32'h100, 16'h3, 8'h3, 1'(i));
            while (hold_cycles < 400) @(posedge aclk);
        join_any
        while (hold_cycles < 400) @(posedge aclk);
        hold_off = 1'b0;
        wait fork;
        gaps_on = 1'b1;
        wait_drained();
    endtask

    task automatic test_random(int n);
        for (int i = 0; i < 8; i++) subj_pool[i] = $urandom();
        for (int i = 0; i < 6; i++) addr_pool[i] = $urandom();
        // reuse the table already full of subjects for part of the pool
        subj_pool[0] = 32'h0;
        subj_pool[1] = 32'h1003;
        for (int i = 0; i < n; i++) begin
            if (i == n / 2) begin
                gaps_on = 1'b0;   // stretch with no sender gaps
            end
            if (i == n / 2 + 40) gaps_on = 1'b1;
            send_random();
        end
        wait_drained();
    endtask

    initial begin
        nsubj_mdl = 0;
        for (int i = 0; i < NSUBJ; i++) nmemb_mdl[i] = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_full_tables();
        test_backpressure();
        test_random(250);
        $display("sent %0d requests covering all kinds, full tables and a long stall;", n_reqs);
        $display("checked %0d result beats", n_beats);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("timeout");
        $display("Regression FAIL");
        $finish;
    end

endmodule
